[design/mwe_pkg.sv]
// ----------------------------------------------------------------------------
// mwe_pkg: shared types and constants of the microwire word master
// Phase and instruction-stage codes, pin and configuration structs,
// register indexes and reset values, and the tick span helpers.
// ----------------------------------------------------------------------------
package mwe_pkg;

   // default geometry of the serial memory (x16 organization)
   localparam int unsigned MWE_ADDR_BITS = 8;
   localparam int unsigned MWE_DATA_BITS = 16;

   // configuration port geometry
   localparam int unsigned TICK_W     = 10;
   localparam int unsigned TIMEOUT_W  = 24;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   // register reset values
   localparam logic [TICK_W-1:0]    SETUP_RESET      = 10'd2;
   localparam logic [TICK_W-1:0]    HOLD_RESET       = 10'd2;
   localparam logic [TICK_W-1:0]    SELECT_LOW_RESET = 10'd4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 24'd100000;

   // instruction opcodes following the start bit
   localparam logic [1:0] OPC_READ  = 2'b10;
   localparam logic [1:0] OPC_WRITE = 2'b01;
   localparam logic [1:0] OPC_EXT   = 2'b00;

   // register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETUP,
      CSR_HOLD,
      CSR_SELECT_LOW,
      CSR_TIMEOUT
   } csr_index_type;

   // timing phase of the serial engine
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_GAP,
      PH_SETUP,
      PH_HIGH,
      PH_CLOSE_HOLD,
      PH_CLOSE_LOW,
      PH_POLL
   } phase_type;

   // which instruction or bit group is being shifted
   typedef enum logic [2:0] {
      ST_RD_INSTR,
      ST_RD_DUMMY,
      ST_RD_DATA,
      ST_WEN,
      ST_WR_INSTR,
      ST_WR_DATA,
      ST_WDS
   } stage_type;

   // pin levels of the memory interface
   typedef struct packed {
      logic pe;
      logic oe;
      logic dout;
      logic cs;
      logic sk;
   } pin_type;

   // timing configuration
   typedef struct packed {
      logic [TICK_W-1:0]    setup;
      logic [TICK_W-1:0]    hold;
      logic [TICK_W-1:0]    select_low;
      logic [TIMEOUT_W-1:0] timeout;
   } cfg_type;

   // a programmed count of zero acts as one
   function automatic logic [TICK_W-1:0] span_ticks(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   function automatic logic [TIMEOUT_W-1:0] span_wait(input logic [TIMEOUT_W-1:0] v);
      return (v == '0) ? TIMEOUT_W'(1) : v;
   endfunction

endpackage

[design/mwe_csr.sv]
// ----------------------------------------------------------------------------
// mwe_csr: timing register bank
// Holds the setup, hold, select-low and ready-timeout counts, written
// through an index/data channel that is always ready.
// ----------------------------------------------------------------------------
module mwe_csr
   import mwe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SETUP:      cfg_in.setup      = csr_data[TICK_W-1:0];
            CSR_HOLD:       cfg_in.hold       = csr_data[TICK_W-1:0];
            CSR_SELECT_LOW: cfg_in.select_low = csr_data[TICK_W-1:0];
            CSR_TIMEOUT:    cfg_in.timeout    = csr_data[TIMEOUT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{setup: SETUP_RESET, hold: HOLD_RESET,
                     select_low: SELECT_LOW_RESET, timeout: TIMEOUT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/microwire_eeprom_word_master_unit.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_word_master_unit: word master for a microwire serial memory
// Runs read and write word accesses of a 93C66-style memory in x16 mode,
// one protocol tick per item.
// ----------------------------------------------------------------------------
// Each item on the req channel is one tick of the serial protocol and yields
// exactly one rsp item with the pin levels driven during that tick, busy and
// done flags, the last read word and the status of the last access. The block
// takes one item per clock cycle; the tick logic sits between the state
// registers and a single result register, so a result appears in the cycle after
// its item, and the next item is taken at the same edge that hands that result
// on, so a result held back by rsp_tready also holds back the req channel. A
// start request is only honored while idle. A read sends start, opcode 10 and
// the address, floats the data line, clocks one dummy bit and samples the word
// MSB first. A write raises PE, sends write-enable, the write instruction and
// the word, then polls the data line for ready; on ready it sends
// write-disable, on timeout it ends with status 1 and drops PE. Timing counts
// come from four registers on the csr port; a count of zero acts as one.
// ----------------------------------------------------------------------------
module microwire_eeprom_word_master_unit
   import mwe_pkg::*;
#(
   parameter int unsigned ADDR_BITS = MWE_ADDR_BITS,
   parameter int unsigned DATA_BITS = MWE_DATA_BITS,
   localparam int unsigned REQ_BITS = ADDR_BITS + DATA_BITS + 2,
   localparam int unsigned REQ_W    = ((REQ_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_BITS = DATA_BITS + 8,
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: start_req, word_addr, write_data, serial_in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // req_tuser: op
   input  logic                  req_tuser,
   // rsp_tdata: serial_clock, chip_select, serial_out, serial_out_enable,
   // program_enable, busy_res, done_res, read_word, status
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned SHIFT_W = (ADDR_BITS + 3 > DATA_BITS) ? ADDR_BITS + 3 : DATA_BITS;
   localparam int unsigned CNT_W   = $clog2(SHIFT_W + 1);

   // instruction word: start bit, opcode, address
   function automatic logic [SHIFT_W-1:0] instr_word(input logic [1:0] opc,
                                                     input logic [ADDR_BITS-1:0] a);
      return SHIFT_W'({1'b1, opc, a});
   endfunction

   cfg_type cfg;

   // timing registers
   mwe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // item fields
   logic                 in_start;
   logic                 in_op;
   logic [ADDR_BITS-1:0] in_addr;
   logic [DATA_BITS-1:0] in_wdata;
   logic                 in_sin;

   assign in_start = req_tdata[0];
   assign in_op    = req_tuser;
   assign in_addr  = req_tdata[ADDR_BITS:1];
   assign in_wdata = req_tdata[ADDR_BITS+DATA_BITS:ADDR_BITS+1];
   assign in_sin   = req_tdata[ADDR_BITS+DATA_BITS+1];

   // engine state
   phase_type            phase_ff, phase_in;
   stage_type            stage_ff, stage_in;
   logic [CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [TICK_W-1:0]    delay_ff, delay_in;
   logic [TIMEOUT_W-1:0] wait_ff, wait_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 op_ff, op_in;
   pin_type              pins_ff, pins_in;
   logic [DATA_BITS-1:0] read_ff, read_in;
   logic                 status_ff, status_in;

   // per-tick working signals
   pin_type              pins_out;
   logic                 done;
   logic                 busy;
   logic                 pe;
   logic                 recv;
   logic                 bitv;
   logic [SHIFT_W-1:0]   shifted;
   logic [TICK_W:0]      dc_inc;
   logic [TIMEOUT_W-1:0] wait_inc;

   // result register
   logic                 rsp_valid_ff;
   logic [RSP_W-1:0]     rsp_data_ff;
   logic                 req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state and pin levels for one tick
   always_comb begin
      phase_in   = phase_ff;
      stage_in   = stage_ff;
      bit_cnt_in = bit_cnt_ff;
      delay_in   = delay_ff;
      wait_in    = wait_ff;
      shift_in   = shift_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      op_in      = op_ff;
      pins_in    = pins_ff;
      read_in    = read_ff;
      status_in  = status_ff;
      done       = 1'b0;
      pins_out   = '{oe: 1'b1, default: 1'b0};
      pe         = 1'b0;
      recv       = 1'b0;
      bitv       = 1'b0;
      shifted    = '0;
      dc_inc     = '0;
      wait_inc   = '0;

      // latch a new access while idle
      if (phase_ff == PH_IDLE && in_start) begin
         op_in      = in_op;
         addr_in    = in_addr;
         data_in    = in_wdata;
         pins_in    = '{oe: 1'b1, pe: in_op, default: 1'b0};
         wait_in    = '0;
         phase_in   = PH_GAP;
         delay_in   = '0;
         bit_cnt_in = CNT_W'(ADDR_BITS + 3);
         if (in_op) begin
            stage_in = ST_WEN;
            shift_in = instr_word(OPC_EXT, '1);
         end else begin
            stage_in = ST_RD_INSTR;
            shift_in = instr_word(OPC_READ, in_addr);
         end
      end

      if (phase_in == PH_IDLE) begin
         pins_in  = '{oe: 1'b1, default: 1'b0};
         pins_out = '{oe: 1'b1, default: 1'b0};
      end else begin
         pe       = pins_in.pe;
         pins_out = '{oe: 1'b1, pe: pe, default: 1'b0};
         recv     = (stage_in == ST_RD_DUMMY) || (stage_in == ST_RD_DATA);
         shifted  = shift_in >> (bit_cnt_in - 1'b1);
         bitv     = (bit_cnt_in != '0) && shifted[0];
         dc_inc   = {1'b0, delay_in} + 1'b1;
         wait_inc = wait_in + 1'b1;

         case (phase_in)
            // chip select low before an instruction
            PH_GAP: begin
               if (dc_inc >= {1'b0, span_ticks(cfg.select_low)}) begin
                  delay_in = '0;
                  phase_in = PH_SETUP;
               end else begin
                  delay_in = dc_inc[TICK_W-1:0];
               end
            end
            // one bit: data setup with clock low, then clock high
            PH_SETUP, PH_HIGH: begin
               pins_out = '{pe: pe, cs: 1'b1, oe: !recv, dout: !recv && bitv, sk: 1'b0};
               if (phase_in == PH_HIGH) begin
                  pins_out.sk = 1'b1;
                  if (dc_inc >= {1'b0, span_ticks(cfg.hold)}) begin
                     delay_in = '0;
                     if (bit_cnt_in != '0) begin
                        bit_cnt_in = bit_cnt_in - 1'b1;
                     end
                     if (bit_cnt_in == '0) begin
                        // bit group complete
                        case (stage_in)
                           ST_RD_INSTR: begin
                              stage_in   = ST_RD_DUMMY;
                              bit_cnt_in = CNT_W'(1);
                              phase_in   = PH_SETUP;
                           end
                           ST_RD_DUMMY: begin
                              stage_in   = ST_RD_DATA;
                              bit_cnt_in = CNT_W'(DATA_BITS);
                              shift_in   = '0;
                              phase_in   = PH_SETUP;
                           end
                           ST_WR_INSTR: begin
                              stage_in   = ST_WR_DATA;
                              bit_cnt_in = CNT_W'(DATA_BITS);
                              shift_in   = SHIFT_W'(data_in);
                              phase_in   = PH_SETUP;
                           end
                           ST_RD_DATA: begin
                              read_in  = shift_in[DATA_BITS-1:0];
                              phase_in = PH_CLOSE_HOLD;
                           end
                           default: phase_in = PH_CLOSE_HOLD;
                        endcase
                     end else begin
                        phase_in = PH_SETUP;
                     end
                  end else begin
                     delay_in = dc_inc[TICK_W-1:0];
                  end
               end else if (dc_inc >= {1'b0, span_ticks(cfg.setup)}) begin
                  // sample on the last setup tick of a data bit
                  if (stage_in == ST_RD_DATA) begin
                     shift_in = SHIFT_W'({shift_in[DATA_BITS-2:0], in_sin});
                  end
                  delay_in = '0;
                  phase_in = PH_HIGH;
               end else begin
                  delay_in = dc_inc[TICK_W-1:0];
               end
            end
            // clock low with select still high
            PH_CLOSE_HOLD: begin
               pins_out    = pins_in;
               pins_out.sk = 1'b0;
               if (dc_inc >= {1'b0, span_ticks(cfg.hold)}) begin
                  delay_in = '0;
                  phase_in = PH_CLOSE_LOW;
               end else begin
                  delay_in = dc_inc[TICK_W-1:0];
               end
            end
            // select low, then move to the next instruction, to polling or back to idle
            PH_CLOSE_LOW: begin
               if (dc_inc >= {1'b0, span_ticks(cfg.select_low)}) begin
                  delay_in = '0;
                  if (stage_in == ST_WEN) begin
                     stage_in   = ST_WR_INSTR;
                     phase_in   = PH_GAP;
                     shift_in   = instr_word(OPC_WRITE, addr_in);
                     bit_cnt_in = CNT_W'(ADDR_BITS + 3);
                  end else if (stage_in == ST_WR_DATA) begin
                     phase_in = PH_POLL;
                     wait_in  = '0;
                  end else begin
                     phase_in  = PH_IDLE;
                     status_in = 1'b0;
                     done      = 1'b1;
                  end
               end else begin
                  delay_in = dc_inc[TICK_W-1:0];
               end
            end
            // wait for ready after programming, ending with status 1 on timeout
            PH_POLL: begin
               pins_out = '{pe: pe, cs: 1'b1, default: 1'b0};
               if (in_sin) begin
                  stage_in   = ST_WDS;
                  phase_in   = PH_GAP;
                  delay_in   = '0;
                  shift_in   = instr_word(OPC_EXT, '0);
                  bit_cnt_in = CNT_W'(ADDR_BITS + 3);
               end else begin
                  wait_in = wait_inc;
                  if (wait_inc >= span_wait(cfg.timeout)) begin
                     phase_in  = PH_IDLE;
                     status_in = 1'b1;
                     done      = 1'b1;
                  end
               end
            end
            default: begin
               phase_in  = PH_IDLE;
               status_in = 1'b0;
               done      = 1'b1;
            end
         endcase
         pins_in = pins_out;
      end

      busy = (phase_in != PH_IDLE);
   end

   // state registers, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stage_ff   <= ST_RD_INSTR;
         bit_cnt_ff <= '0;
         delay_ff   <= '0;
         wait_ff    <= '0;
         shift_ff   <= '0;
         addr_ff    <= '0;
         data_ff    <= '0;
         op_ff      <= 1'b0;
         pins_ff    <= '{oe: 1'b1, default: 1'b0};
         read_ff    <= '0;
         status_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         stage_ff   <= stage_in;
         bit_cnt_ff <= bit_cnt_in;
         delay_ff   <= delay_in;
         wait_ff    <= wait_in;
         shift_ff   <= shift_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         op_ff      <= op_in;
         pins_ff    <= pins_in;
         read_ff    <= read_in;
         status_ff  <= status_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= RSP_W'({status_in, read_in, done, busy, pins_out.pe, pins_out.oe,
                                pins_out.dout, pins_out.cs, pins_out.sk});
      end
   end

endmodule
